>>> sv/slm_pkg.sv
// slm_pkg: shared types and codes for the sorted list merger
// controller/datapath command and status structs, request mode codes
// no dependencies
package slm_pkg;

   localparam int VALUE_W = 32;
   localparam int MODE_W = 2;

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_PUSH_A = 2'd0;
   localparam mode_type MODE_PUSH_B = 2'd1;
   localparam mode_type MODE_START  = 2'd2;

   typedef struct packed {
      logic push_a;
      logic push_b;
      logic emit;
      logic clear;
   } slm_cmd_type;

   typedef struct packed {
      logic empty;
      logic out_free;
      logic last_pick;
   } slm_sts_type;

endpackage

>>> sv/slm_ctrl.sv
// slm_ctrl: controller state machine of the sorted list merger
// decodes request words, sequences the merge, drives datapath commands
// depends on slm_pkg
module slm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  slm_pkg::mode_type    req_mode,
   output slm_pkg::slm_cmd_type cmd,
   input  slm_pkg::slm_sts_type sts
);
   import slm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_MERGE = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_PUSH_A: cmd.push_a = 1'b1;
                  MODE_PUSH_B: cmd.push_b = 1'b1;
                  MODE_START: begin
                     if (!sts.empty) begin
                        state_in = ST_MERGE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.last_pick) begin
                  cmd.clear = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/slm_dpath.sv
// slm_dpath: datapath of the sorted list merger
// two list stores with registered read heads, counts, merge indexes, output word register
// depends on slm_pkg
module slm_dpath #(
   parameter int DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  slm_pkg::slm_cmd_type               cmd,
   output slm_pkg::slm_sts_type               sts,
   input  logic signed [slm_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [slm_pkg::VALUE_W-1:0] rsp_merged_value,
   output logic                               rsp_last
);
   import slm_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   logic signed [VALUE_W-1:0] store_a [DEPTH];
   logic signed [VALUE_W-1:0] store_b [DEPTH];

   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic [CW-1:0] idx_a_ff, idx_a_in;
   logic [CW-1:0] idx_b_ff, idx_b_in;
   logic signed [VALUE_W-1:0] head_a_ff, head_b_ff;
   logic          write_a, write_b;
   logic          take_a;
   logic [CW:0]   sum_pos, sum_tot;
   logic signed [VALUE_W-1:0] pick;
   logic          out_free;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;

   assign write_a = cmd.push_a && (count_a_ff != FULL);
   assign write_b = cmd.push_b && (count_b_ff != FULL);

   // list a wins ties
   assign take_a = (idx_a_ff < count_a_ff) &&
                   ((idx_b_ff >= count_b_ff) || (head_a_ff <= head_b_ff));
   assign pick = take_a ? head_a_ff : head_b_ff;

   assign sum_pos = {1'b0, idx_a_ff} + {1'b0, idx_b_ff} + (CW + 1)'(1);
   assign sum_tot = {1'b0, count_a_ff} + {1'b0, count_b_ff};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sts.empty = (count_a_ff == '0) && (count_b_ff == '0);
   assign sts.out_free = out_free;
   assign sts.last_pick = (sum_pos == sum_tot);

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      idx_a_in = idx_a_ff;
      idx_b_in = idx_b_ff;
      if (cmd.clear) begin
         count_a_in = '0;
         count_b_in = '0;
         idx_a_in = '0;
         idx_b_in = '0;
      end else begin
         if (write_a) begin
            count_a_in = count_a_ff + CW'(1);
         end
         if (write_b) begin
            count_b_in = count_b_ff + CW'(1);
         end
         if (cmd.emit) begin
            if (take_a) begin
               idx_a_in = idx_a_ff + CW'(1);
            end else begin
               idx_b_in = idx_b_ff + CW'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
         idx_a_ff <= '0;
         idx_b_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         idx_a_ff <= idx_a_in;
         idx_b_ff <= idx_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stores: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (write_a) begin
         store_a[count_a_ff[AW-1:0]] <= req_value;
      end
      head_a_ff <= store_a[idx_a_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (write_b) begin
         store_b[count_b_ff[AW-1:0]] <= req_value;
      end
      head_b_ff <= store_b[idx_b_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff <= pick;
         rsp_last_ff <= sts.last_pick;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_last = rsp_last_ff;

endmodule

>>> sv/sorted_list_merger_unit.sv
// sorted_list_merger_unit: two-way merge of two ascending lists of signed 32-bit values.
// A push word (mode 0 list a, mode 1 list b) appends its value; a push to a full list is
// dropped. A start word (mode 2) holds off new request words until the merge run ends,
// emitting one merged word per cycle while the result side does not stall, from the
// registered read ports of the two list stores, with last set on the final word; list a
// goes first on equal values, both counts clear after the run, and a start with both
// lists empty emits nothing. Mode 3 is ignored.
// Request words are taken while a finished result word still waits in the output register.
// Depends on slm_pkg, slm_ctrl, slm_dpath.
module sorted_list_merger_unit #(
   parameter int DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  slm_pkg::mode_type                  req_mode,
   input  logic signed [slm_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [slm_pkg::VALUE_W-1:0] rsp_merged_value,
   output logic                               rsp_last
);
   import slm_pkg::*;

   slm_cmd_type cmd;
   slm_sts_type sts;

   slm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .cmd       (cmd),
      .sts       (sts)
   );

   slm_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_last         (rsp_last)
   );

endmodule

>>> tb/sv/tb.sv
// tb: self-checking bench for sorted_list_merger_unit, loads of list a and list b words and
// merge starts, checked word by word against an in-bench merge of the two lists
// depends on slm_pkg and sorted_list_merger_unit
`timescale 1ns / 1ps

module tb;
   import slm_pkg::*;

   localparam int LIST_DEPTH = 32;
   localparam int RUN_LIMIT = 200000;
   localparam int TAIL_CYCLES = 100;
   localparam int LOAD_TARGET = 130;
   localparam mode_type MODE_UNUSED = 2'd3;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef value_type value_q_type[$];

   typedef struct packed {
      mode_type  mode;
      value_type value;
      logic      hold;
      logic [6:0] idle_pct;
   } req_word_type;

   typedef struct packed {
      value_type value;
      logic      last;
   } merged_word_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   mode_type  req_mode = MODE_PUSH_A;
   value_type req_value = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   value_type rsp_merged_value;
   logic      rsp_last;

   value_type list_a [LIST_DEPTH];
   value_type list_b [LIST_DEPTH];
   int fill_a = 0;
   int fill_b = 0;

   req_word_type    pending[$];
   merged_word_type merged_due[$];
   req_word_type    cur_word;

   int tx_gap = 0;
   int rx_gap = 0;
   int idle_pct = 0;
   int mismatches = 0;
   int cycles = 0;
   int load_words = 0;

   sorted_list_merger_unit #(
      .DEPTH(LIST_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_merged_value(rsp_merged_value),
      .rsp_last(rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   task automatic track_request(input req_word_type w);
      int ia;
      int ib;
      int total;
      merged_word_type m;
      ia = 0;
      ib = 0;
      case (w.mode)
         MODE_PUSH_A: begin
            if (fill_a < LIST_DEPTH) begin
               list_a[fill_a] = w.value;
               fill_a++;
            end
         end
         MODE_PUSH_B: begin
            if (fill_b < LIST_DEPTH) begin
               list_b[fill_b] = w.value;
               fill_b++;
            end
         end
         MODE_START: begin
            total = fill_a + fill_b;
            for (int k = 0; k < total; k++) begin
               if (ia < fill_a && (ib >= fill_b || list_a[ia] <= list_b[ib])) begin
                  m.value = list_a[ia];
                  ia++;
               end else begin
                  m.value = list_b[ib];
                  ib++;
               end
               m.last = (k == total - 1);
               merged_due.insert(merged_due.size(), m);
            end
            fill_a = 0;
            fill_b = 0;
         end
         default: ;
      endcase
   endtask

   task automatic add_word(input mode_type mode, input value_type value, input int pct);
      req_word_type w;
      w.mode = mode;
      w.value = value;
      w.hold = 1'b0;
      w.idle_pct = 7'(pct);
      pending.insert(pending.size(), w);
      load_words++;
   endtask

   task automatic add_hold(input int pct);
      req_word_type w;
      w.mode = MODE_UNUSED;
      w.value = '0;
      w.hold = 1'b1;
      w.idle_pct = 7'(pct);
      pending.insert(pending.size(), w);
   endtask

   function automatic value_q_type make_list(input int n, input bit in_order, input bit tight);
      value_q_type q;
      longint cur;
      longint step;
      if (tight) cur = longint'($urandom_range(8)) - 4;
      else if ($urandom_range(3) == 0) cur = longint'(32'sh8000_0000);
      else cur = longint'(int'($urandom));
      for (int i = 0; i < n; i++) begin
         if (!in_order) begin
            cur = tight ? longint'($urandom_range(8)) - 4 : longint'(int'($urandom));
         end else if (i > 0) begin
            step = tight ? longint'($urandom_range(2)) : longint'($urandom_range(32'h0800_0000));
            cur = cur + step;
            if (cur > longint'(32'sh7fff_ffff)) cur = longint'(32'sh7fff_ffff);
         end
         q.insert(q.size(), cur[VALUE_W-1:0]);
      end
      return q;
   endfunction

   task automatic add_merge_run(input int na, input int nb, input bit in_order,
                                input bit tight, input int pct);
      value_q_type a;
      value_q_type b;
      int ia;
      int ib;
      a = make_list(na, in_order, tight);
      b = make_list(nb, in_order, tight);
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
         if ($urandom_range(9) == 0) add_word(MODE_UNUSED, int'($urandom), pct);
         if (ib >= nb || (ia < na && $urandom_range(1) == 0)) begin
            add_word(MODE_PUSH_A, a[ia], pct);
            ia++;
         end else begin
            add_word(MODE_PUSH_B, b[ib], pct);
            ib++;
         end
      end
      add_word(MODE_START, int'($urandom), pct);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_valid && !req_stall) track_request(cur_word);
         if (!req_valid || !req_stall) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (pending.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending[0].hold) begin
               if (merged_due.size() == 0) begin
                  idle_pct = int'(pending[0].idle_pct);
                  pending.delete(0);
               end
               req_valid <= 1'b0;
            end else if ($urandom_range(99) < idle_pct) begin
               tx_gap = $urandom_range(10);
               req_valid <= 1'b0;
            end else begin
               cur_word = pending.pop_front();
               idle_pct = int'(cur_word.idle_pct);
               req_valid <= 1'b1;
               req_mode <= cur_word.mode;
               req_value <= cur_word.value;
            end
         end
      end
   end

   always @(posedge clock) begin : rx_side
      merged_word_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (merged_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected word %0d last %0b",
                                       rsp_merged_value, rsp_last));
            end else begin
               due = merged_due.pop_front();
               if (rsp_merged_value !== due.value)
                  flag_mismatch($sformatf("merged_value %0d, want %0d",
                                          rsp_merged_value, due.value));
               if (rsp_last !== due.last)
                  flag_mismatch($sformatf("last %0b, want %0b", rsp_last, due.last));
            end
         end
         if (rx_gap > 0) begin
            rx_gap--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(99) < idle_pct) begin
            rx_gap = $urandom_range(10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int na;
      int nb;
      int pct;

      // empty merge, ignored mode, ties at both extremes
      add_word(MODE_START, 32'sh5555_5555, 20);
      add_word(MODE_UNUSED, -32'sd1, 20);
      add_word(MODE_PUSH_A, 32'sh8000_0000, 20);
      add_word(MODE_PUSH_B, 32'sh8000_0000, 20);
      add_word(MODE_PUSH_A, 32'sh7fff_ffff, 20);
      add_word(MODE_PUSH_B, 32'sh7fff_ffff, 20);
      add_word(MODE_START, -32'sd1, 20);
      // one list empty
      add_word(MODE_PUSH_A, -32'sd1, 20);
      add_word(MODE_PUSH_A, 32'sd0, 20);
      add_word(MODE_START, 32'sh2aaa_aaaa, 20);
      add_word(MODE_PUSH_B, 32'sd5, 20);
      add_word(MODE_UNUSED, 32'sd7, 20);
      add_word(MODE_START, 32'sd0, 20);
      // unsorted lists
      add_word(MODE_PUSH_A, 32'sd10, 20);
      add_word(MODE_PUSH_A, -32'sd10, 20);
      add_word(MODE_PUSH_B, 32'sd0, 20);
      add_word(MODE_PUSH_B, 32'sd20, 20);
      add_word(MODE_PUSH_B, -32'sd5, 20);
      add_word(MODE_START, 32'sd0, 20);
      add_word(MODE_START, 32'sd0, 20);
      add_hold(20);

      // both lists past full
      add_merge_run(LIST_DEPTH + 1, LIST_DEPTH + 1, 1'b1, 1'b0, 15);
      add_hold(15);
      while (load_words < LOAD_TARGET) begin
         case ($urandom_range(2))
            0: pct = 0;
            1: pct = 15;
            default: pct = 40;
         endcase
         if (load_words > LOAD_TARGET - 30) pct = 0;
         na = $urandom_range(6);
         nb = $urandom_range(6);
         if ($urandom_range(7) == 0) na = $urandom_range(LIST_DEPTH / 2);
         if ($urandom_range(7) == 0) nb = $urandom_range(LIST_DEPTH / 2);
         add_merge_run(na, nb, $urandom_range(7) != 0, 1'($urandom_range(1)), pct);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending.size() != 0 || req_valid || merged_due.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
